// File: rtl/gbs_pkg.sv
package gbs_pkg;

    localparam int COORD_W     = 16;
    localparam int THR_W       = 17;
    localparam int POS_W       = 16;
    localparam int TOTAL_W     = 7;
    localparam int MAX_KEPT_DEF = 64;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(29491);

    // Stored box: corner plus size, the way it sits in the kept store.
    typedef struct packed {
        logic signed [COORD_W-1:0] left_edge;
        logic signed [COORD_W-1:0] top_edge;
        logic [COORD_W-1:0]        box_width;
        logic [COORD_W-1:0]        box_height;
    } t_box;

    localparam int BOX_W = $bits(t_box);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// File: rtl/gbs_if.sv
interface gbs_box_if;
    import gbs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      start_of_set;
    logic signed [COORD_W-1:0] left_edge;
    logic signed [COORD_W-1:0] top_edge;
    logic [COORD_W-1:0]        box_width;
    logic [COORD_W-1:0]        box_height;

    modport source (output valid, start_of_set, left_edge, top_edge, box_width, box_height,
                    input ready);
    modport sink (input valid, start_of_set, left_edge, top_edge, box_width, box_height,
                  output ready);
endinterface

interface gbs_res_if;
    import gbs_pkg::*;

    logic               valid;
    logic               ready;
    logic               keep;
    logic [POS_W-1:0]   set_position;
    logic               store_overflow;
    logic [TOTAL_W-1:0] kept_total;

    modport source (output valid, keep, set_position, store_overflow, kept_total,
                    input ready);
    modport sink (input valid, keep, set_position, store_overflow, kept_total,
                  output ready);
endinterface

interface gbs_cfg_if;
    import gbs_pkg::*;

    logic             valid;
    logic             ready;
    logic [THR_W-1:0] overlap_threshold;

    modport source (output valid, overlap_threshold, input ready);
    modport sink (input valid, overlap_threshold, output ready);
endinterface

// File: rtl/greedy_box_suppression.sv
// Channel  | Dir | Modport       | Moves per transaction
// ---------+-----+---------------+-----------------------------------------------
// i_box    | in  | gbs_box_if    | one box: start flag, left, top, width, height
// o_res    | out | gbs_res_if    | keep, set position, overflow flag, kept total
// i_cfg    | in  | gbs_cfg_if    | new overlap threshold (Q1.16, 17 bits)
//
// Each box is compared with every kept box in the store, at most MAX_KEPT of them.
// One kept box is read from the store each cycle and enters the overlap pipeline,
// which is six registers deep (store read, edges, two products, union, threshold
// product, compare), so the store's single read port sets the pace. The next box
// is taken once the state machine is back in idle after the result register loads.
// Reset clears the state machine, the kept count and the position counter and
// returns the threshold to its default; the store itself is not cleared, since only
// entries below the count are read. The block takes no box while one is in flight,
// and a finished result stalls in the last state only while the output register is
// still occupied.
module greedy_box_suppression #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbs_box_if.sink   i_box,
    gbs_res_if.source o_res,
    gbs_cfg_if.sink   i_cfg
);

    import gbs_pkg::*;

    // Address reaches every entry; the count must also hold MAX_KEPT itself.
    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int EDGE_W = COORD_W + 2;
    localparam int AREA_W = 2 * COORD_W;
    localparam int UNI_W  = AREA_W + 1;
    localparam int PROD_W = THR_W + UNI_W;
    localparam int FRAC_W = 16;

    // Control and configuration state.
    t_state             r_state;
    t_state             n_state;
    logic [THR_W-1:0]   r_thr;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_idx;
    logic [POS_W-1:0]   r_pos;

    // The box under test, captured when its transaction completes.
    t_box               r_cur;
    logic signed [EDGE_W-1:0] r_cur_right;
    logic signed [EDGE_W-1:0] r_cur_bottom;
    logic [AREA_W-1:0]  r_cur_area;
    logic [POS_W-1:0]   r_cur_pos;
    logic               r_supp;

    // Output register.
    logic               r_out_valid;
    logic               r_out_keep;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_ovf;
    logic [TOTAL_W-1:0] r_out_total;

    // Sequencer outputs.
    logic               box_ready;
    logic               issue;
    logic               finish;

    logic               box_take;
    logic [POS_W-1:0]   pos_base;

    // Overlap pipeline: valid tags and stage registers.
    logic               r_v0, r_v1, r_v2, r_v3, r_v4;
    logic [COORD_W-1:0] r_a_dx, r_a_dy, r_a_kw, r_a_kh;
    logic [AREA_W-1:0]  r_b_inter, r_b_karea;
    logic [UNI_W-1:0]   r_c_uni;
    logic [AREA_W-1:0]  r_c_inter;
    logic [PROD_W-1:0]  r_d_prod;
    logic [AREA_W-1:0]  r_d_inter;
    logic               r_d_unz;
    logic               pipe_busy;

    // Store access.
    logic [BOX_W-1:0]   rd_data;
    t_box               kbox;
    logic               wr_en;
    logic               store_full;
    logic               keep_now;

    // Edge arithmetic of stage A.
    logic signed [EDGE_W-1:0]  k_right, k_bottom;
    logic signed [COORD_W-1:0] x1, y1;
    logic signed [EDGE_W-1:0]  x2, y2;
    logic signed [EDGE_W:0]    diff_x, diff_y;

    assign box_take  = i_box.valid && box_ready;
    assign pos_base  = i_box.start_of_set ? '0 : r_pos;
    assign pipe_busy = r_v0 || r_v1 || r_v2 || r_v3 || r_v4;

    assign store_full = (r_cnt == CNT_W'(MAX_KEPT));
    assign keep_now   = !r_supp;
    assign wr_en      = finish && keep_now && !store_full;

    // Configuration: the threshold is taken only between boxes, and a box that is
    // offered in the same cycle goes first, so a scan always sees one threshold.
    assign i_cfg.ready = (r_state == ST_IDLE) && !i_box.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_thr <= i_cfg.overlap_threshold;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_box.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // All kept boxes issued and the last one has left the pipeline.
                if ((r_idx == r_cnt) && !pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        box_ready = 1'b0;
        issue     = 1'b0;
        finish    = 1'b0;
        unique case (r_state)
            ST_IDLE:   box_ready = 1'b1;
            ST_SCAN:   issue     = (r_idx < r_cnt);
            ST_FINISH: finish    = !r_out_valid || o_res.ready;
            default: begin
                box_ready = 1'b0;
            end
        endcase
    end

    assign i_box.ready = box_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Count, position and scan index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pos <= '0;
            r_idx <= '0;
        end else begin
            if (box_take) begin
                r_idx <= '0;
                r_pos <= (pos_base != '1) ? pos_base + POS_W'(1) : pos_base;
                if (i_box.start_of_set) begin
                    r_cnt <= '0;
                end
            end else if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (wr_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Capture of the incoming box; its own right and bottom edges and area are
    // worked out once here.
    always_ff @(posedge i_clk) begin
        if (box_take) begin
            r_cur.left_edge  <= i_box.left_edge;
            r_cur.top_edge   <= i_box.top_edge;
            r_cur.box_width  <= i_box.box_width;
            r_cur.box_height <= i_box.box_height;
            r_cur_right  <= EDGE_W'(i_box.left_edge) + $signed({2'b00, i_box.box_width});
            r_cur_bottom <= EDGE_W'(i_box.top_edge) + $signed({2'b00, i_box.box_height});
            r_cur_area   <= AREA_W'(i_box.box_width) * AREA_W'(i_box.box_height);
            r_cur_pos    <= pos_base;
        end
    end

    gbs_ram #(
        .WIDTH  (BOX_W),
        .DEPTH  (MAX_KEPT),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[ADDR_W-1:0]),
        .i_wr_data (r_cur),
        .i_rd_en   (issue),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Stage A: intersection extents of the box under test and one kept box.
    // The intersection width can never exceed either box's width, so it fits
    // 16 bits once it is known to be positive.
    assign kbox     = t_box'(rd_data);
    assign k_right  = EDGE_W'(kbox.left_edge) + $signed({2'b00, kbox.box_width});
    assign k_bottom = EDGE_W'(kbox.top_edge) + $signed({2'b00, kbox.box_height});
    assign x1 = (r_cur.left_edge > kbox.left_edge) ? r_cur.left_edge : kbox.left_edge;
    assign y1 = (r_cur.top_edge > kbox.top_edge) ? r_cur.top_edge : kbox.top_edge;
    assign x2 = (r_cur_right < k_right) ? r_cur_right : k_right;
    assign y2 = (r_cur_bottom < k_bottom) ? r_cur_bottom : k_bottom;
    assign diff_x = (EDGE_W + 1)'(x2) - (EDGE_W + 1)'(x1);
    assign diff_y = (EDGE_W + 1)'(y2) - (EDGE_W + 1)'(y1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage A: an empty overlap in either axis gives zero extents.
        if ((diff_x > 0) && (diff_y > 0)) begin
            r_a_dx <= diff_x[COORD_W-1:0];
            r_a_dy <= diff_y[COORD_W-1:0];
        end else begin
            r_a_dx <= '0;
            r_a_dy <= '0;
        end
        r_a_kw <= kbox.box_width;
        r_a_kh <= kbox.box_height;

        // Stage B: intersection area and kept box area.
        r_b_inter <= AREA_W'(r_a_dx) * AREA_W'(r_a_dy);
        r_b_karea <= AREA_W'(r_a_kw) * AREA_W'(r_a_kh);

        // Stage C: union; the intersection never exceeds either area.
        r_c_uni   <= UNI_W'(r_cur_area) + UNI_W'(r_b_karea) - UNI_W'(r_b_inter);
        r_c_inter <= r_b_inter;

        // Stage D: threshold scaled union.
        r_d_prod  <= PROD_W'(r_thr) * PROD_W'(r_c_uni);
        r_d_inter <= r_c_inter;
        r_d_unz   <= (r_c_uni != '0);
    end

    // Stage E: a kept box with IoU above the threshold suppresses the new one.
    always_ff @(posedge i_clk) begin
        if (box_take) begin
            r_supp <= 1'b0;
        end else if (r_v4 && r_d_unz &&
                     (PROD_W'({r_d_inter, FRAC_W'(0)}) > r_d_prod)) begin
            r_supp <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_keep  <= keep_now;
            r_out_pos   <= r_cur_pos;
            r_out_ovf   <= keep_now && store_full;
            r_out_total <= wr_en ? TOTAL_W'(r_cnt + CNT_W'(1)) : TOTAL_W'(r_cnt);
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.keep           = r_out_keep;
    assign o_res.set_position   = r_out_pos;
    assign o_res.store_overflow = r_out_ovf;
    assign o_res.kept_total     = r_out_total;

endmodule

// File: rtl/gbs_ram.sv
module gbs_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: bench/greedy_box_suppression_tb.sv
`timescale 1ns / 1ps

module greedy_box_suppression_tb;
    import gbs_pkg::*;

    localparam int KEPT_DEPTH       = MAX_KEPT_DEF;
    localparam int RANDOM_PER_PHASE = 600;
    localparam int DRAIN_CYCLES     = MAX_KEPT_DEF + 16;
    localparam int N_DIRECTED       = 25;
    // The watchdog is several times the slowest legal run: every box scanning
    // a full store behind a receiver that stalls most of the time.
    localparam longint WATCHDOG_NS  = 64'd10_000_000;

    typedef longint unsigned t_u64;

    // One result as it appears on the result channel.
    typedef struct packed {
        logic               keep;
        logic [POS_W-1:0]   set_position;
        logic               store_overflow;
        logic [TOTAL_W-1:0] kept_total;
    } t_nms_result;

    // A result typed into the directed table, travelling with its box.
    typedef struct packed {
        logic        has;
        t_nms_result res;
    } t_pinned_result;

    typedef enum logic {
        ROW_BOX,
        ROW_THRESHOLD
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        bit        sos;
        int        left;
        int        top;
        int        wid;
        int        hgt;
        int        thr;
        bit        pinned;
        bit        keep;
        int        pos;
        bit        ovf;
        int        total;
    } t_directed_row;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    gbs_box_if box_ch ();
    gbs_res_if res_ch ();
    gbs_cfg_if cfg_ch ();

    greedy_box_suppression dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_box   (box_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #5 clk = ~clk;

    // Our own copy of the suppression state: the kept boxes of the current
    // set, their count, the position counter and the threshold register.
    t_box             kept_store [KEPT_DEPTH];
    int               kept_n = 0;
    int               set_pos = 0;
    logic [THR_W-1:0] thr_q = THR_RESET;

    t_nms_result    expected_results [$];
    t_pinned_result row_check = '0;

    int send_idle_pct = 16;
    int recv_idle_pct = 68;
    logic recv_ready = 1'b0;

    int mismatches   = 0;
    int boxes_sent   = 0;
    int n_results    = 0;
    int n_kept       = 0;
    int n_overflow   = 0;
    int n_thr_writes = 0;

    // Directed table. Columns: kind, start flag, left, top, width, height,
    // threshold (threshold rows only), pinned flag, then the pinned keep,
    // position, overflow and kept total. Rows without a pin are checked
    // against the predictor. Coordinates are raw Q12.4 values.
    t_directed_row directed_rows [N_DIRECTED] = '{
        // No start flag yet: the boxes after reset form one set.
        '{ROW_BOX, 0, 0, 0, 16, 16, 0, 1, 1, 0, 0, 1},
        '{ROW_BOX, 0, 0, 0, 16, 16, 0, 1, 0, 1, 0, 1},
        // Coordinate extremes; the second box starts exactly at the right
        // and bottom edges of the first, so the edges must not wrap.
        '{ROW_BOX, 1, -32768, -32768, 65535, 65535, 0, 1, 1, 0, 0, 1},
        '{ROW_BOX, 0, 32767, 32767, 65535, 65535, 0, 1, 1, 1, 0, 2},
        // Two empty boxes on one point: their union is zero, so no suppression.
        '{ROW_BOX, 0, 0, 0, 0, 0, 0, 1, 1, 2, 0, 3},
        '{ROW_BOX, 0, 0, 0, 0, 0, 0, 1, 1, 3, 0, 4},
        '{ROW_BOX, 0, -32768, -32768, 65535, 65535, 0, 1, 0, 4, 0, 4},
        // Partial overlaps on either side of the reset threshold.
        '{ROW_BOX, 1, 0, 0, 160, 160, 0, 1, 1, 0, 0, 1},
        '{ROW_BOX, 0, 80, 0, 160, 160, 0, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 16, 0, 160, 160, 0, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 16, 0, 160, 0, 0, 0, 0, 0, 0},
        // Zero threshold: touching boxes survive, any overlap suppresses.
        '{ROW_THRESHOLD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BOX, 1, 0, 0, 160, 160, 0, 1, 1, 0, 0, 1},
        '{ROW_BOX, 0, 160, 0, 160, 160, 0, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 319, 0, 160, 160, 0, 0, 0, 0, 0, 0},
        // Threshold of one: a perfect overlap is not above it.
        '{ROW_THRESHOLD, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 0},
        '{ROW_BOX, 1, 100, 100, 320, 320, 0, 1, 1, 0, 0, 1},
        '{ROW_BOX, 0, 100, 100, 320, 320, 0, 1, 1, 1, 0, 2},
        // Threshold above one: nothing can be suppressed.
        '{ROW_THRESHOLD, 0, 0, 0, 0, 0, 131071, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 100, 100, 320, 320, 0, 1, 1, 2, 0, 3},
        // Half: an overlap of exactly one half survives, a hair more does not.
        '{ROW_THRESHOLD, 0, 0, 0, 0, 0, 32768, 0, 0, 0, 0, 0},
        '{ROW_BOX, 1, 0, 0, 32, 32, 0, 1, 1, 0, 0, 1},
        '{ROW_BOX, 0, 0, 0, 32, 16, 0, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 0, 32, 17, 0, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, -32768, 32767, 65535, 0, 0, 0, 0, 0, 0, 0}
    };

    // The receiver stalls at random; the channel's ready follows one register.
    assign res_ch.ready = recv_ready;

    always @(posedge clk) begin
        recv_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Greedy suppression of one box against the kept boxes of its set. The
    // overlap test is done without division, in 64-bit arithmetic, so the
    // right and bottom edges never wrap.
    function automatic t_nms_result predict_outcome(input logic sos, input t_box cur);
        t_nms_result r;
        longint cx1, cy1, cx2, cy2, kx1, ky1, kx2, ky2, ix, iy;
        t_u64 area_cur, area_k, inter, uni;
        logic survive;
        int i;
        survive = 1'b1;
        if (sos) begin
            kept_n = 0;
            set_pos = 0;
        end
        cx1 = longint'($signed(cur.left_edge));
        cy1 = longint'($signed(cur.top_edge));
        cx2 = cx1 + longint'(cur.box_width);
        cy2 = cy1 + longint'(cur.box_height);
        area_cur = t_u64'(cur.box_width) * t_u64'(cur.box_height);
        for (i = 0; i < kept_n; i++) begin
            kx1 = longint'($signed(kept_store[i].left_edge));
            ky1 = longint'($signed(kept_store[i].top_edge));
            kx2 = kx1 + longint'(kept_store[i].box_width);
            ky2 = ky1 + longint'(kept_store[i].box_height);
            ix = ((cx2 < kx2) ? cx2 : kx2) - ((cx1 > kx1) ? cx1 : kx1);
            iy = ((cy2 < ky2) ? cy2 : ky2) - ((cy1 > ky1) ? cy1 : ky1);
            inter = (ix > 0 && iy > 0) ? t_u64'(ix * iy) : t_u64'(0);
            area_k = t_u64'(kept_store[i].box_width) * t_u64'(kept_store[i].box_height);
            uni = area_cur + area_k - inter;
            if (uni != 0 && (inter << 16) > t_u64'(thr_q) * uni)
                survive = 1'b0;
        end
        r.keep = survive;
        r.store_overflow = 1'b0;
        if (survive) begin
            if (kept_n < KEPT_DEPTH) begin
                kept_store[kept_n] = cur;
                kept_n++;
            end else begin
                r.store_overflow = 1'b1;
            end
        end
        r.set_position = POS_W'(set_pos);
        if (set_pos < 65535)
            set_pos++;
        r.kept_total = TOTAL_W'(kept_n);
        return r;
    endfunction

    // Scoreboard. Both channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands, so the order of processes in a
    // time step does not matter. An accepted box is predicted at once; an
    // accepted result is compared with the oldest expectation.
    always @(posedge clk) begin : scoreboard
        t_box        geom;
        t_nms_result predicted;
        t_nms_result want;
        if (rst_n) begin
            if (box_ch.valid && box_ch.ready) begin
                geom.left_edge  = box_ch.left_edge;
                geom.top_edge   = box_ch.top_edge;
                geom.box_width  = box_ch.box_width;
                geom.box_height = box_ch.box_height;
                predicted = predict_outcome(box_ch.start_of_set, geom);
                expected_results.insert(expected_results.size(),
                                        row_check.has ? row_check.res : predicted);
            end
            if (res_ch.valid && res_ch.ready) begin
                n_results++;
                if (res_ch.keep)
                    n_kept++;
                if (res_ch.store_overflow)
                    n_overflow++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no box pending, set_position",
                                    res_ch.set_position, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.keep !== want.keep)
                        report_mismatch("keep", res_ch.keep, want.keep);
                    if (res_ch.set_position !== want.set_position)
                        report_mismatch("set_position", res_ch.set_position,
                                        want.set_position);
                    if (res_ch.store_overflow !== want.store_overflow)
                        report_mismatch("store_overflow", res_ch.store_overflow,
                                        want.store_overflow);
                    if (res_ch.kept_total !== want.kept_total)
                        report_mismatch("kept_total", res_ch.kept_total, want.kept_total);
                end
            end
        end
    end

    // Offers one box, after a random run of idle cycles, and returns at the
    // edge where the transaction completes. Valid stays high into the next
    // box unless that box idles first, so valid gets one assignment per step.
    task automatic send_box(input logic sos, input int l, input int t, input int w,
                            input int h, input t_pinned_result pin);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            box_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        box_ch.valid        <= 1'b1;
        box_ch.start_of_set <= sos;
        box_ch.left_edge    <= 16'(l);
        box_ch.top_edge     <= 16'(t);
        box_ch.box_width    <= 16'(w);
        box_ch.box_height   <= 16'(h);
        row_check           <= pin;
        do @(posedge clk); while (!box_ch.ready);
        boxes_sent++;
    endtask

    // Holds the sender back until every result that is owed has arrived.
    task automatic wait_quiet();
        box_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // Threshold writes happen only with the block drained.
    task automatic write_threshold(input logic [THR_W-1:0] value);
        wait_quiet();
        cfg_ch.valid             <= 1'b1;
        cfg_ch.overlap_threshold <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        thr_q = value;
        n_thr_writes++;
    endtask

    // Mostly useful thresholds, with the edges and full 17-bit noise mixed in.
    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(7))
            0: return '0;
            1: return THR_W'(65536);
            2: return {THR_W{1'b1}};
            3: return THR_RESET;
            7: return THR_W'($urandom);
            default: return THR_W'($urandom_range(58982, 16384));
        endcase
    endfunction

    initial begin : stimulus
        t_pinned_result pin;
        t_pinned_result no_pin;
        int phase, phase_base, set_idx, style, len, i, a, n_anchor, flavor;
        int sx, sy, sz, top, l, t, w, h;
        logic sos;
        int ax [4];
        int ay [4];
        int aw [4];
        int ah [4];

        no_pin = '0;
        box_ch.valid             <= 1'b0;
        box_ch.start_of_set      <= 1'b0;
        box_ch.left_edge         <= '0;
        box_ch.top_edge          <= '0;
        box_ch.box_width         <= '0;
        box_ch.box_height        <= '0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.overlap_threshold <= '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset threshold until the table changes it.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_THRESHOLD) begin
                write_threshold(THR_W'(directed_rows[r].thr));
            end else begin
                pin.has                = directed_rows[r].pinned;
                pin.res.keep           = directed_rows[r].keep;
                pin.res.set_position   = POS_W'(directed_rows[r].pos);
                pin.res.store_overflow = directed_rows[r].ovf;
                pin.res.kept_total     = TOTAL_W'(directed_rows[r].total);
                send_box(directed_rows[r].sos, directed_rows[r].left, directed_rows[r].top,
                         directed_rows[r].wid, directed_rows[r].hgt, pin);
            end
        end

        // Random part in three idling regimes. Most traffic is whole sets of
        // boxes clustered around a few anchors, so that overlaps land near the
        // threshold; the rest is disjoint sets that overflow the store, raw noise,
        // stray start flags and sets that never got one.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct <= 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct <= 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            write_threshold(pick_threshold());
            phase_base = boxes_sent;
            set_idx = 0;
            while (boxes_sent - phase_base < RANDOM_PER_PHASE) begin
                if (set_idx != 0 && $urandom_range(11) == 0)
                    write_threshold(pick_threshold());
                // The first set of each phase always fills the kept store.
                style = (set_idx == 0) ? 9 : $urandom_range(99);
                set_idx++;
                if (style < 6) begin
                    len = $urandom_range(4, 1);
                    for (i = 0; i < len; i++)
                        send_box(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                                 $urandom, no_pin);
                end else if (style < 10) begin
                    // Disjoint boxes, more than the store holds: the tail of
                    // the set is kept with the overflow flag.
                    len = $urandom_range(KEPT_DEPTH + 8, KEPT_DEPTH + 1);
                    sz = $urandom_range(800, 16);
                    top = int'($urandom_range(60000)) - 30000;
                    for (i = 0; i < len; i++)
                        send_box(i == 0, -32768 + i * 900, top, sz, sz, no_pin);
                end else begin
                    n_anchor = $urandom_range(4, 1);
                    for (i = 0; i < n_anchor; i++) begin
                        ax[i] = int'($urandom_range(32000)) - 16000;
                        ay[i] = int'($urandom_range(32000)) - 16000;
                        aw[i] = $urandom_range(4000, 16);
                        ah[i] = $urandom_range(4000, 16);
                    end
                    len = $urandom_range(24, 1);
                    for (i = 0; i < len; i++) begin
                        sos = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
                        a = $urandom_range(n_anchor - 1);
                        flavor = $urandom_range(9);
                        // Wide jitter mostly lands below the threshold and
                        // tight jitter above it.
                        sx = (flavor < 4) ? aw[a] / 4 : aw[a] / 16 + 1;
                        sy = (flavor < 4) ? ah[a] / 4 : ah[a] / 16 + 1;
                        l = ax[a] + int'($urandom_range(2 * sx)) - sx;
                        t = ay[a] + int'($urandom_range(2 * sy)) - sy;
                        w = aw[a] + int'($urandom_range(2 * sx)) - sx;
                        h = ah[a] + int'($urandom_range(2 * sy)) - sy;
                        if (flavor == 7) begin
                            if ($urandom_range(1))
                                w = 0;
                            else
                                h = 0;
                        end else if (flavor == 8) begin
                            l = $urandom;
                            t = $urandom;
                            w = $urandom;
                            h = $urandom;
                        end else if (flavor == 9) begin
                            l = int'($urandom_range(60000)) - 30000;
                            t = int'($urandom_range(60000)) - 30000;
                        end
                        send_box(sos, l, t, w, h, no_pin);
                        if ($urandom_range(49) == 0)
                            wait_quiet();
                    end
                end
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d boxes with %0d results: %0d kept, %0d suppressed, %0d overflows.",
                 boxes_sent, n_results, n_kept, n_results - n_kept, n_overflow);
        $display("Threshold written %0d times across three stall regimes.", n_thr_writes);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #(WATCHDOG_NS);
        $display("Timeout with %0d results still pending.", expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
rtl/gbs_pkg.sv
rtl/gbs_if.sv
rtl/gbs_ram.sv
rtl/greedy_box_suppression.sv
bench/greedy_box_suppression_tb.sv
